### rtl/core/msm_pkg.sv
`default_nettype none

package msm_pkg;

   localparam int MAX_WINDOW = 32;
   localparam int COORD_BITS = 24;

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int IDX_W = $clog2(MAX_WINDOW);
   localparam int SUM_W = COORD_BITS + IDX_W;
   localparam int THR_W = 23;
   localparam int WIN_W = 6;
   localparam int CMP_W = CNT_W + WIN_W;
   localparam int MUL_W = (COORD_BITS > THR_W) ? COORD_BITS : THR_W;
   localparam int ACC_W = 2 * MUL_W + 2;
   localparam int ITER_W = $clog2(SUM_W + 1);

   localparam logic [63:0] DIFF_CAP = 64'h0000_0000_8000_0000;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 23;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_WINDOW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVING_WINDOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_THRESHOLD  = 3'd4;

   localparam logic             RST_TRACK_ENABLE    = 1'b1;
   localparam logic [THR_W-1:0] RST_STILL_THRESHOLD = 23'd26;
   localparam logic [WIN_W-1:0] RST_STILL_WINDOW    = 6'd30;
   localparam logic [WIN_W-1:0] RST_MOVING_WINDOW   = 6'd2;
   localparam logic [THR_W-1:0] RST_MOVE_THRESHOLD  = 23'd26;

   localparam int STEP_W = 3;
   localparam int MUL_STEPS = 8;
   localparam int MUL_DRAIN = 2;
   localparam int CTR_W = $clog2(MUL_STEPS + MUL_DRAIN);

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_STILL_X   = 3'd0;
   localparam step_type STEP_STILL_Y   = 3'd1;
   localparam step_type STEP_STILL_Z   = 3'd2;
   localparam step_type STEP_PAIR_X    = 3'd3;
   localparam step_type STEP_PAIR_Y    = 3'd4;
   localparam step_type STEP_PAIR_Z    = 3'd5;
   localparam step_type STEP_STILL_THR = 3'd6;
   localparam step_type STEP_MOVE_THR  = 3'd7;

   localparam logic ACTION_SAMPLE    = 1'b0;
   localparam logic ACTION_CALIBRATE = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic [CNT_W-1:0]             cnt_type;
   typedef logic [IDX_W-1:0]             idx_type;
   typedef logic [MUL_W-1:0]             mul_type;
   typedef logic [ACC_W-1:0]             acc_type;
   typedef logic [THR_W-1:0]             thr_type;
   typedef logic [WIN_W-1:0]             win_type;
   typedef logic [2:0][COORD_BITS-1:0]   pos_type;

   typedef struct packed {
      logic     load;
      logic     mul_en;
      step_type mul_step;
      logic     still_upd;
      logic     drop;
      logic     cal_load;
      logic     append;
      logic     div_start;
      logic     filt_from_div;
      logic     out_load;
   } cmd_type;

   typedef struct packed {
      logic    action;
      logic    enable;
      logic    full;
      logic    over_limit;
      logic    div_busy;
      cnt_type count;
   } status_type;

   typedef struct packed {
      coord_type filt_x;
      coord_type filt_y;
      coord_type filt_z;
      cnt_type   window_count;
      logic      is_still;
      logic      jumped;
   } rsp_payload_type;

endpackage

`default_nettype wire

### rtl/core/msm_if.sv
`default_nettype none

interface msm_req_if import msm_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      action;
   coord_type pos_x;
   coord_type pos_y;
   coord_type pos_z;

   modport source (output valid, output action, output pos_x, output pos_y, output pos_z,
                   input ready);
   modport sink (input valid, input action, input pos_x, input pos_y, input pos_z,
                 output ready);
endinterface

interface msm_rsp_if import msm_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type filt_x;
   coord_type filt_y;
   coord_type filt_z;
   cnt_type   window_count;
   logic      is_still;
   logic      jumped;

   modport source (output valid, output filt_x, output filt_y, output filt_z,
                   output window_count, output is_still, output jumped, input ready);
   modport sink (input valid, input filt_x, input filt_y, input filt_z,
                 input window_count, input is_still, input jumped, output ready);
endinterface

`default_nettype wire

### rtl/core/msm_div.sv
`default_nettype none

module msm_div import msm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  sum_type   sum,
   input  cnt_type   divisor,
   output logic      busy,
   output coord_type quotient
);

   logic              busy_ff, busy_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   cnt_type           den_ff, den_in;
   cnt_type           rem_ff, rem_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   logic [SUM_W-1:0]  mag;
   logic [CNT_W:0]    shifted;
   logic [CNT_W:0]    diff;
   logic              ge;

   always_comb begin
      mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      diff = shifted - {1'b0, den_ff};
      ge = (shifted >= {1'b0, den_ff});

      busy_in = busy_ff;
      neg_in = neg_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      iter_in = iter_ff;

      if (start) begin
         neg_in = sum[SUM_W-1];
         quo_in = mag + SUM_W'(divisor >> 1);
         den_in = divisor;
         rem_in = '0;
         iter_in = ITER_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], ge};
         iter_in = iter_ff - ITER_W'(1);
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      iter_ff <= iter_in;
   end

   assign busy = busy_ff;
   assign quotient = neg_ff ? COORD_BITS'(-quo_ff) : COORD_BITS'(quo_ff);

endmodule

`default_nettype wire

### rtl/core/msm_ctrl.sv
`default_nettype none

module msm_ctrl import msm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_MUL      = 8'b0000_0010,
      ST_DECIDE   = 8'b0000_0100,
      ST_APPEND   = 8'b0000_1000,
      ST_TRIM     = 8'b0001_0000,
      ST_DIV_GO   = 8'b0010_0000,
      ST_DIV_WAIT = 8'b0100_0000,
      ST_OUTPUT   = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CTR_W-1:0] ctr_ff, ctr_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      ctr_in = ctr_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               ctr_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (ctr_ff < CTR_W'(MUL_STEPS)) begin
               cmd.mul_en = 1'b1;
               cmd.mul_step = ctr_ff[STEP_W-1:0];
            end
            if (ctr_ff == CTR_W'(MUL_STEPS + MUL_DRAIN - 1)) begin
               state_in = ST_DECIDE;
            end else begin
               ctr_in = ctr_ff + CTR_W'(1);
            end
         end
         ST_DECIDE: begin
            if (status.action == ACTION_CALIBRATE) begin
               cmd.cal_load = 1'b1;
               state_in = ST_OUTPUT;
            end else if (!status.enable) begin
               state_in = ST_OUTPUT;
            end else begin
               cmd.still_upd = 1'b1;
               cmd.drop = status.full;
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in = ST_TRIM;
         end
         ST_TRIM: begin
            if (status.over_limit) begin
               cmd.drop = 1'b1;
            end else begin
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               cmd.filt_from_div = 1'b1;
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ctr_ff <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/core/msm_dp.sv
`default_nettype none

module msm_dp import msm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_action,
   input  coord_type             req_pos_x,
   input  coord_type             req_pos_y,
   input  coord_type             req_pos_z,
   input  cmd_type               cmd,
   output status_type            status,
   output rsp_payload_type       rsp_data
);

   function automatic mul_type cap_mag(input coord_type a, input coord_type b);
      logic signed [COORD_BITS:0] d;
      logic [COORD_BITS:0]        m;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      m = d[COORD_BITS] ? (COORD_BITS+1)'(-d) : d;
      if (64'(m) > DIFF_CAP) begin
         return MUL_W'(DIFF_CAP);
      end
      return MUL_W'(m);
   endfunction

   function automatic sum_type sext_sum(input coord_type v);
      return {{(SUM_W-COORD_BITS){v[COORD_BITS-1]}}, v};
   endfunction

   // configuration
   logic    track_enable_ff, track_enable_in;
   thr_type still_thr_ff, still_thr_in;
   win_type still_win_ff, still_win_in;
   win_type moving_win_ff, moving_win_in;
   thr_type move_thr_ff, move_thr_in;

   // window state
   cnt_type   count_ff, count_in;
   idx_type   oldest_ff, oldest_in;
   sum_type   sum_ff [3];
   sum_type   sum_in [3];
   coord_type filt_ff [3];
   coord_type filt_in [3];
   logic      still_ff, still_in;

   // item and distance state
   logic      action_ff, action_in;
   coord_type p_ff [3];
   coord_type p_in [3];
   coord_type last_ff [3];
   coord_type last_in [3];
   acc_type   pair_dist_ff, pair_dist_in;
   acc_type   still_acc_ff, still_acc_in;
   acc_type   pair_acc_ff, pair_acc_in;
   acc_type   still_sq_ff, still_sq_in;
   acc_type   move_sq_ff, move_sq_in;

   // squarer pipeline
   mul_type            op_in, op_ff;
   step_type           op_tag_ff;
   logic               op_vld_ff;
   logic [2*MUL_W-1:0] prod_ff;
   step_type           prod_tag_ff;
   logic               prod_vld_ff;

   pos_type store_mem [MAX_WINDOW];
   pos_type rd_ff;
   idx_type wr_idx;

   rsp_payload_type out_ff, out_in;

   coord_type quo [3];
   logic      div_busy [3];

   win_type win_sel;
   cnt_type limit;
   logic [CNT_W:0] slot_sum;

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : gen_div
         msm_div u_div (
            .clock    (clock),
            .reset    (reset),
            .start    (cmd.div_start),
            .sum      (sum_ff[g]),
            .divisor  (count_ff),
            .busy     (div_busy[g]),
            .quotient (quo[g])
         );
      end
   endgenerate

   always_comb begin
      win_sel = still_ff ? still_win_ff : moving_win_ff;
      if (win_sel == '0) begin
         limit = CNT_W'(1);
      end else if (CMP_W'(win_sel) > CMP_W'(MAX_WINDOW)) begin
         limit = CNT_W'(MAX_WINDOW);
      end else begin
         limit = CNT_W'(win_sel);
      end

      slot_sum = (CNT_W+1)'(oldest_ff) + (CNT_W+1)'(count_ff);
      if (slot_sum >= (CNT_W+1)'(MAX_WINDOW)) begin
         slot_sum = slot_sum - (CNT_W+1)'(MAX_WINDOW);
      end
      wr_idx = slot_sum[IDX_W-1:0];
   end

   always_comb begin
      case (cmd.mul_step)
         STEP_STILL_X:   op_in = cap_mag(p_ff[0], filt_ff[0]);
         STEP_STILL_Y:   op_in = cap_mag(p_ff[1], filt_ff[1]);
         STEP_STILL_Z:   op_in = cap_mag(p_ff[2], filt_ff[2]);
         STEP_PAIR_X:    op_in = cap_mag(p_ff[0], last_ff[0]);
         STEP_PAIR_Y:    op_in = cap_mag(p_ff[1], last_ff[1]);
         STEP_PAIR_Z:    op_in = cap_mag(p_ff[2], last_ff[2]);
         STEP_STILL_THR: op_in = MUL_W'(still_thr_ff);
         STEP_MOVE_THR:  op_in = MUL_W'(move_thr_ff);
         default:        op_in = '0;
      endcase
   end

   always_comb begin
      track_enable_in = track_enable_ff;
      still_thr_in = still_thr_ff;
      still_win_in = still_win_ff;
      moving_win_in = moving_win_ff;
      move_thr_in = move_thr_ff;
      count_in = count_ff;
      oldest_in = oldest_ff;
      still_in = still_ff;
      action_in = action_ff;
      pair_dist_in = pair_dist_ff;
      still_acc_in = still_acc_ff;
      pair_acc_in = pair_acc_ff;
      still_sq_in = still_sq_ff;
      move_sq_in = move_sq_ff;
      out_in = out_ff;
      for (int a = 0; a < 3; a++) begin
         sum_in[a] = sum_ff[a];
         filt_in[a] = filt_ff[a];
         p_in[a] = p_ff[a];
         last_in[a] = last_ff[a];
      end

      if (csr_write_enable) begin
         case (csr_index)
            CSR_TRACK_ENABLE:    track_enable_in = csr_data[0];
            CSR_STILL_THRESHOLD: still_thr_in = csr_data[THR_W-1:0];
            CSR_STILL_WINDOW:    still_win_in = csr_data[WIN_W-1:0];
            CSR_MOVING_WINDOW:   moving_win_in = csr_data[WIN_W-1:0];
            CSR_MOVE_THRESHOLD:  move_thr_in = csr_data[THR_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         action_in = req_action;
         p_in[0] = req_pos_x;
         p_in[1] = req_pos_y;
         p_in[2] = req_pos_z;
         still_acc_in = '0;
         pair_acc_in = '0;
      end

      if (prod_vld_ff) begin
         case (prod_tag_ff)
            STEP_STILL_X, STEP_STILL_Y, STEP_STILL_Z:
               still_acc_in = still_acc_ff + ACC_W'(prod_ff);
            STEP_PAIR_X, STEP_PAIR_Y, STEP_PAIR_Z:
               pair_acc_in = pair_acc_ff + ACC_W'(prod_ff);
            STEP_STILL_THR: still_sq_in = ACC_W'(prod_ff);
            STEP_MOVE_THR:  move_sq_in = ACC_W'(prod_ff);
            default: ;
         endcase
      end

      if (cmd.still_upd) begin
         still_in = (still_acc_ff < still_sq_ff);
      end

      if (cmd.drop) begin
         for (int a = 0; a < 3; a++) begin
            sum_in[a] = sum_ff[a] - sext_sum(coord_type'(rd_ff[a]));
         end
         oldest_in = (oldest_ff == IDX_W'(MAX_WINDOW - 1)) ? '0 : oldest_ff + IDX_W'(1);
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.append) begin
         for (int a = 0; a < 3; a++) begin
            sum_in[a] = sum_ff[a] + sext_sum(p_ff[a]);
            last_in[a] = p_ff[a];
         end
         count_in = count_ff + CNT_W'(1);
         pair_dist_in = pair_acc_ff;
      end

      if (cmd.cal_load) begin
         for (int a = 0; a < 3; a++) begin
            filt_in[a] = p_ff[a];
         end
      end

      if (cmd.filt_from_div) begin
         for (int a = 0; a < 3; a++) begin
            filt_in[a] = quo[a];
         end
      end

      if (cmd.out_load) begin
         out_in.filt_x = filt_ff[0];
         out_in.filt_y = filt_ff[1];
         out_in.filt_z = filt_ff[2];
         out_in.window_count = count_ff;
         out_in.is_still = still_ff;
         out_in.jumped = (count_ff >= CNT_W'(2)) && (pair_dist_ff > move_sq_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_enable_ff <= RST_TRACK_ENABLE;
         still_thr_ff <= RST_STILL_THRESHOLD;
         still_win_ff <= RST_STILL_WINDOW;
         moving_win_ff <= RST_MOVING_WINDOW;
         move_thr_ff <= RST_MOVE_THRESHOLD;
         count_ff <= '0;
         oldest_ff <= '0;
         still_ff <= 1'b0;
         op_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= '0;
            filt_ff[a] <= '0;
         end
      end else begin
         track_enable_ff <= track_enable_in;
         still_thr_ff <= still_thr_in;
         still_win_ff <= still_win_in;
         moving_win_ff <= moving_win_in;
         move_thr_ff <= move_thr_in;
         count_ff <= count_in;
         oldest_ff <= oldest_in;
         still_ff <= still_in;
         op_vld_ff <= cmd.mul_en;
         prod_vld_ff <= op_vld_ff;
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= sum_in[a];
            filt_ff[a] <= filt_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      pair_dist_ff <= pair_dist_in;
      still_acc_ff <= still_acc_in;
      pair_acc_ff <= pair_acc_in;
      still_sq_ff <= still_sq_in;
      move_sq_ff <= move_sq_in;
      op_ff <= op_in;
      op_tag_ff <= cmd.mul_step;
      prod_ff <= op_ff * op_ff;
      prod_tag_ff <= op_tag_ff;
      out_ff <= out_in;
      for (int a = 0; a < 3; a++) begin
         p_ff[a] <= p_in[a];
         last_ff[a] <= last_in[a];
      end
   end

   // sample store, read port follows the next oldest slot
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         store_mem[wr_idx] <= {p_ff[2], p_ff[1], p_ff[0]};
      end
      rd_ff <= store_mem[oldest_in];
   end

   always_comb begin
      status.action = action_ff;
      status.enable = track_enable_ff;
      status.full = (count_ff == CNT_W'(MAX_WINDOW));
      status.over_limit = (count_ff > limit);
      status.div_busy = div_busy[0] | div_busy[1] | div_busy[2];
      status.count = count_ff;
   end

   assign rsp_data = out_ff;

endmodule

`default_nettype wire

### rtl/core/motion_adaptive_position_smoother_unit.sv
// Motion-adaptive position smoother: each tracked sample item appends a 3-D position
// to a ring window of up to MAX_WINDOW entries, trims it to the still or moving window
// size, and returns the rounded mean as the filtered position, with window count,
// still flag and jump flag; a calibrate item sets the filtered position only. One item
// is worked at a time. A tracked sample uses the shared squarer, drops up to MAX_WINDOW
// samples from the window one at a time over the store read port, and ends in the
// SUM_W-step restoring divider. A finished result waits in an output register while
// the next item is accepted.
`default_nettype none

module motion_adaptive_position_smoother_unit import msm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   msm_req_if.sink               req_ch,
   msm_rsp_if.source             rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type         cmd;
   status_type      status;
   rsp_payload_type rsp_data;
   logic            req_fire;

   msm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   msm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_action       (req_ch.action),
      .req_pos_x        (req_ch.pos_x),
      .req_pos_y        (req_ch.pos_y),
      .req_pos_z        (req_ch.pos_z),
      .cmd              (cmd),
      .status           (status),
      .rsp_data         (rsp_data)
   );

   assign rsp_ch.filt_x = rsp_data.filt_x;
   assign rsp_ch.filt_y = rsp_data.filt_y;
   assign rsp_ch.filt_z = rsp_data.filt_z;
   assign rsp_ch.window_count = rsp_data.window_count;
   assign rsp_ch.is_still = rsp_data.is_still;
   assign rsp_ch.jumped = rsp_data.jumped;

   assign req_fire = req_ch.valid && req_ch.ready;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("input still ready after an item was accepted");

   a_out_reg_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("output register overwritten while a result is pending");

   a_div_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider started while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (status.count <= CNT_W'(MAX_WINDOW)))
      else $error("window count beyond store depth");

endmodule

`default_nettype wire

### dv/tb_motion_adaptive_position_smoother_unit.sv
`timescale 1ns / 1ps

module tb_motion_adaptive_position_smoother_unit;
   import msm_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int TAIL_CYCLES = 100;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_ITEMS = 165;
   localparam int DISABLED_ITEMS = 40;
   localparam longint unsigned GAP_CAP = 64'h0000_0000_8000_0000;
   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef longint triple_type [3];
   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic                  action;
      coord_type             x;
      coord_type             y;
      coord_type             z;
      logic                  typed;
      rsp_payload_type       result;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   msm_req_if req_ch ();
   msm_rsp_if rsp_ch ();

   motion_adaptive_position_smoother_unit uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // shadow of the block's registers and state
   logic       cfg_track_enable;
   thr_type    cfg_still_threshold;
   win_type    cfg_still_window;
   win_type    cfg_moving_window;
   thr_type    cfg_move_threshold;
   triple_type window_store [MAX_WINDOW];
   int unsigned window_fill;
   int unsigned window_head;
   triple_type window_sum;
   triple_type smoothed;
   logic       still_state;

   rsp_payload_type pending_filtered [$];
   longint cursor [3];
   bit idle_enabled;
   bit hold_off_request;
   int error_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned span_sq(triple_type a, triple_type b);
      longint unsigned total;
      longint unsigned d;
      int k;
      total = 0;
      for (k = 0; k < 3; k++) begin
         d = (a[k] >= b[k]) ? longint'(a[k] - b[k]) : longint'(b[k] - a[k]);
         if (d > GAP_CAP) d = GAP_CAP;
         total += d * d;
      end
      return total;
   endfunction

   function automatic void drop_oldest();
      int k;
      for (k = 0; k < 3; k++) window_sum[k] -= window_store[window_head][k];
      window_head = (window_head + 1) % MAX_WINDOW;
      window_fill--;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_TRACK_ENABLE: cfg_track_enable = value[0];
         CSR_STILL_THRESHOLD: cfg_still_threshold = value[THR_W-1:0];
         CSR_STILL_WINDOW: cfg_still_window = value[WIN_W-1:0];
         CSR_MOVING_WINDOW: cfg_moving_window = value[WIN_W-1:0];
         CSR_MOVE_THRESHOLD: cfg_move_threshold = value[THR_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic rsp_payload_type smooth_position(logic act, coord_type px,
                                                       coord_type py, coord_type pz);
      triple_type p;
      longint unsigned lim_sq;
      longint unsigned mag;
      longint unsigned q;
      int unsigned lim;
      int unsigned slot_n;
      int k;
      rsp_payload_type r;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      if (act == ACTION_CALIBRATE) begin
         for (k = 0; k < 3; k++) smoothed[k] = p[k];
      end else if (cfg_track_enable) begin
         lim_sq = longint'(cfg_still_threshold) * longint'(cfg_still_threshold);
         still_state = span_sq(p, smoothed) < lim_sq;
         if (window_fill >= MAX_WINDOW) drop_oldest();
         slot_n = (window_head + window_fill) % MAX_WINDOW;
         window_store[slot_n] = p;
         for (k = 0; k < 3; k++) window_sum[k] += p[k];
         window_fill++;
         lim = still_state ? cfg_still_window : cfg_moving_window;
         if (lim == 0) lim = 1;
         else if (lim > MAX_WINDOW) lim = MAX_WINDOW;
         while (window_fill > lim) drop_oldest();
         // mean rounded half away from zero
         for (k = 0; k < 3; k++) begin
            mag = (window_sum[k] < 0) ? longint'(-window_sum[k]) : longint'(window_sum[k]);
            q = (mag + window_fill / 2) / window_fill;
            smoothed[k] = (window_sum[k] < 0) ? -longint'(q) : longint'(q);
         end
      end
      r.filt_x = coord_type'(smoothed[0]);
      r.filt_y = coord_type'(smoothed[1]);
      r.filt_z = coord_type'(smoothed[2]);
      r.window_count = cnt_type'(window_fill);
      r.is_still = still_state;
      r.jumped = 1'b0;
      if (window_fill >= 2) begin
         lim_sq = longint'(cfg_move_threshold) * longint'(cfg_move_threshold);
         r.jumped = span_sq(window_store[(window_head + window_fill - 1) % MAX_WINDOW],
                            window_store[(window_head + window_fill - 2) % MAX_WINDOW])
                    > lim_sq;
      end
      return r;
   endfunction

   function automatic row_type item_row(logic act, coord_type x, coord_type y, coord_type z);
      row_type r;
      r.kind = ROW_ITEM;
      r.action = act;
      r.x = x;
      r.y = y;
      r.z = z;
      r.typed = 1'b0;
      r.result = '0;
      r.index = '0;
      r.data = '0;
      return r;
   endfunction

   function automatic row_type known_row(logic act, coord_type x, coord_type y, coord_type z,
                                         coord_type fx, coord_type fy, coord_type fz,
                                         cnt_type n, logic s, logic j);
      row_type r;
      r = item_row(act, x, y, z);
      r.typed = 1'b1;
      r.result.filt_x = fx;
      r.result.filt_y = fy;
      r.result.filt_z = fz;
      r.result.window_count = n;
      r.result.is_still = s;
      r.result.jumped = j;
      return r;
   endfunction

   function automatic row_type csr_row(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      row_type r;
      r = item_row(ACTION_SAMPLE, '0, '0, '0);
      r.kind = ROW_CSR;
      r.index = idx;
      r.data = d;
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_threshold();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return CSR_DATA_W'($urandom_range(1, 64));
         3: return CSR_DATA_W'($urandom_range(65, 3000));
         4: return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'(RST_STILL_THRESHOLD);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_window();
      logic [CSR_DATA_W-1:0] w;
      case ($urandom_range(0, 5))
         0: w = '0;
         1: w = CSR_DATA_W'(1);
         2: w = CSR_DATA_W'(MAX_WINDOW);
         3: w = CSR_DATA_W'((1 << WIN_W) - 1);
         4: w = CSR_DATA_W'($urandom_range(0, (1 << WIN_W) - 1));
         default: w = CSR_DATA_W'($urandom_range(2, 8));
      endcase
      return (CSR_DATA_W'($urandom) & ~CSR_DATA_W'((1 << WIN_W) - 1)) | w;
   endfunction

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      apply_register(idx, value);
      @(negedge clock);
      csr_write_enable = 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_filtered.size() != 0) @(posedge clock);
   endtask

   task automatic offer_item(input logic act, input coord_type x, input coord_type y,
                             input coord_type z, input logic typed,
                             input rsp_payload_type typed_result);
      int unsigned gap;
      rsp_payload_type predicted;
      if (idle_enabled && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap) @(posedge clock);
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.action = act;
      req_ch.pos_x = x;
      req_ch.pos_y = y;
      req_ch.pos_z = z;
      do @(posedge clock); while (!req_ch.ready);
      predicted = smooth_position(act, x, y, z);
      pending_filtered.push_back(typed ? typed_result : predicted);
   endtask

   // mostly small steps around a moving cursor, some jumps, extremes and calibrates
   task automatic make_random_item(output logic act, output coord_type x,
                                   output coord_type y, output coord_type z);
      int unsigned pick;
      int unsigned reach;
      longint stepped;
      coord_type c [3];
      int k;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0: reach = 2;
         1: reach = 40;
         2: reach = 400;
         default: reach = 6000;
      endcase
      for (k = 0; k < 3; k++) begin
         if (pick < 8) begin
            cursor[k] = coord_type'($urandom);
         end else if (pick < 12) begin
            case ($urandom_range(0, 3))
               0: cursor[k] = COORD_MIN;
               1: cursor[k] = COORD_MAX;
               2: cursor[k] = 0;
               default: cursor[k] = -1;
            endcase
         end else begin
            stepped = cursor[k] + longint'($urandom_range(0, 2 * reach)) - longint'(reach);
            if (stepped > COORD_MAX) stepped = COORD_MAX;
            if (stepped < COORD_MIN) stepped = COORD_MIN;
            cursor[k] = stepped;
         end
         c[k] = coord_type'(cursor[k]);
      end
      act = (pick >= 95) ? ACTION_CALIBRATE : ACTION_SAMPLE;
      x = c[0];
      y = c[1];
      z = c[2];
   endtask

   task automatic compare_field(input string field, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   initial begin : result_checker
      int unsigned stall_left;
      int unsigned hold_left;
      rsp_payload_type seen;
      rsp_payload_type want;
      stall_left = 0;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (stall_left == 0 && idle_enabled && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 14);
         if (hold_left != 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else if (stall_left != 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            seen.filt_x = rsp_ch.filt_x;
            seen.filt_y = rsp_ch.filt_y;
            seen.filt_z = rsp_ch.filt_z;
            seen.window_count = rsp_ch.window_count;
            seen.is_still = rsp_ch.is_still;
            seen.jumped = rsp_ch.jumped;
            if (pending_filtered.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual x=%0d y=%0d z=%0d",
                        $time, seen.filt_x, seen.filt_y, seen.filt_z);
               error_count++;
            end else begin
               want = pending_filtered.pop_front();
               compare_field("filt_x", want.filt_x, seen.filt_x);
               compare_field("filt_y", want.filt_y, seen.filt_y);
               compare_field("filt_z", want.filt_z, seen.filt_z);
               compare_field("window_count", want.window_count, seen.window_count);
               compare_field("is_still", want.is_still, seen.is_still);
               compare_field("jumped", want.jumped, seen.jumped);
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      row_type rows [$];
      logic [CSR_DATA_W-1:0] v [5];
      rsp_payload_type no_result;
      logic act;
      coord_type x;
      coord_type y;
      coord_type z;
      int k;
      int phase;
      int n;
      int phase_target;

      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.action = ACTION_SAMPLE;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pos_z = '0;
      idle_enabled = 1'b1;
      hold_off_request = 1'b0;
      error_count = 0;
      no_result = '0;

      cfg_track_enable = RST_TRACK_ENABLE;
      cfg_still_threshold = RST_STILL_THRESHOLD;
      cfg_still_window = RST_STILL_WINDOW;
      cfg_moving_window = RST_MOVING_WINDOW;
      cfg_move_threshold = RST_MOVE_THRESHOLD;
      for (k = 0; k < MAX_WINDOW; k++) window_store[k] = '{0, 0, 0};
      window_fill = 0;
      window_head = 0;
      window_sum = '{0, 0, 0};
      smoothed = '{0, 0, 0};
      still_state = 1'b0;
      cursor = '{0, 0, 0};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes and rounding away from zero
      rows.push_back(known_row(ACTION_SAMPLE, 0, 0, 0, 0, 0, 0, 1, 1'b1, 1'b0));
      rows.push_back(known_row(ACTION_CALIBRATE, COORD_MAX, COORD_MIN, COORD_MAX,
                               COORD_MAX, COORD_MIN, COORD_MAX, 1, 1'b1, 1'b0));
      rows.push_back(known_row(ACTION_CALIBRATE, COORD_MIN, COORD_MAX, COORD_MIN,
                               COORD_MIN, COORD_MAX, COORD_MIN, 1, 1'b1, 1'b0));
      rows.push_back(known_row(ACTION_SAMPLE, COORD_MAX, COORD_MAX, COORD_MAX,
                               4194304, 4194304, 4194304, 2, 1'b0, 1'b1));
      rows.push_back(known_row(ACTION_SAMPLE, COORD_MIN, COORD_MIN, COORD_MIN,
                               -1, -1, -1, 2, 1'b0, 1'b1));
      rows.push_back(known_row(ACTION_CALIBRATE, 0, 0, 0, 0, 0, 0, 2, 1'b0, 1'b1));
      rows.push_back(item_row(ACTION_SAMPLE, 0, 0, 5));
      rows.push_back(item_row(ACTION_SAMPLE, 0, 0, 30));
      rows.push_back(item_row(ACTION_SAMPLE, 0, 0, 31));
      rows.push_back(item_row(ACTION_SAMPLE, 20, -20, 0));
      rows.push_back(item_row(ACTION_CALIBRATE, -3, -3, -3));
      rows.push_back(item_row(ACTION_SAMPLE, -3, -3, -3));
      // zero windows act as one
      rows.push_back(csr_row(CSR_MOVING_WINDOW, 0));
      rows.push_back(csr_row(CSR_STILL_WINDOW, 0));
      rows.push_back(csr_row(CSR_STILL_THRESHOLD, 0));
      rows.push_back(item_row(ACTION_SAMPLE, 100, 0, 0));
      rows.push_back(item_row(ACTION_SAMPLE, -100, 0, 0));
      rows.push_back(item_row(ACTION_SAMPLE, -100, 0, 0));
      // oversized still window, everything still, any change is a jump
      rows.push_back(csr_row(CSR_STILL_THRESHOLD, '1));
      rows.push_back(csr_row(CSR_STILL_WINDOW, CSR_DATA_W'((1 << WIN_W) - 1)));
      rows.push_back(csr_row(CSR_MOVE_THRESHOLD, 0));
      rows.push_back(item_row(ACTION_SAMPLE, 5, 5, 5));
      rows.push_back(item_row(ACTION_SAMPLE, 5, 5, 6));
      rows.push_back(item_row(ACTION_SAMPLE, 5, 5, 6));
      rows.push_back(item_row(ACTION_SAMPLE, -7, 9, -11));
      // tracking off
      rows.push_back(csr_row(CSR_TRACK_ENABLE, 0));
      rows.push_back(item_row(ACTION_SAMPLE, 1000, 1000, 1000));
      rows.push_back(item_row(ACTION_CALIBRATE, 7, 8, 9));
      rows.push_back(item_row(ACTION_SAMPLE, COORD_MAX, COORD_MIN, 0));
      // unmapped indexes are ignored
      rows.push_back(csr_row(CSR_TRACK_ENABLE, 1));
      rows.push_back(csr_row(CSR_IDX_W'(CSR_MOVE_THRESHOLD + 1), '1));
      rows.push_back(csr_row('1, '0));
      rows.push_back(item_row(ACTION_SAMPLE, 1, 2, 3));

      foreach (rows[k]) begin
         if (rows[k].kind == ROW_CSR) begin
            wait_for_results();
            write_register(rows[k].index, rows[k].data);
         end else begin
            offer_item(rows[k].action, rows[k].x, rows[k].y, rows[k].z,
                       rows[k].typed, rows[k].result);
         end
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_for_results();
         v[0] = (CSR_DATA_W'($urandom) & ~CSR_DATA_W'(1)) | 1'b1;
         v[1] = pick_threshold();
         v[2] = pick_window();
         v[3] = pick_window();
         v[4] = pick_threshold();
         case (phase)
            1: begin
               v[1] = '1;
               v[2] = CSR_DATA_W'(MAX_WINDOW);
               v[3] = CSR_DATA_W'(MAX_WINDOW);
               v[4] = '0;
            end
            2: begin
               v[1] = '0;
               v[2] = '0;
               v[3] = '0;
               v[4] = '1;
            end
            3: begin
               v[2] = CSR_DATA_W'((1 << WIN_W) - 1);
               v[3] = CSR_DATA_W'(MAX_WINDOW + 1);
            end
            6: v[0] = CSR_DATA_W'($urandom) & ~CSR_DATA_W'(1);
            7: begin
               v[1] = RST_STILL_THRESHOLD;
               v[2] = CSR_DATA_W'(RST_STILL_WINDOW);
               v[3] = CSR_DATA_W'(RST_MOVING_WINDOW);
               v[4] = RST_MOVE_THRESHOLD;
            end
            default: ;
         endcase
         write_register(CSR_TRACK_ENABLE, v[0]);
         write_register(CSR_STILL_THRESHOLD, v[1]);
         write_register(CSR_STILL_WINDOW, v[2]);
         write_register(CSR_MOVING_WINDOW, v[3]);
         write_register(CSR_MOVE_THRESHOLD, v[4]);
         if ($urandom_range(0, 1) == 0)
            write_register(CSR_IDX_W'($urandom_range(CSR_MOVE_THRESHOLD + 1,
                                                     (1 << CSR_IDX_W) - 1)),
                           CSR_DATA_W'($urandom));
         idle_enabled = (phase < PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
         if (phase == 4) begin
            idle_enabled = 1'b1;
            hold_off_request = 1'b1;
         end
         phase_target = (phase == 6) ? DISABLED_ITEMS : PHASE_ITEMS;
         for (n = 0; n < phase_target; n++) begin
            make_random_item(act, x, y, z);
            offer_item(act, x, y, z, 1'b0, no_result);
         end
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_filtered.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### sim.f
rtl/core/msm_pkg.sv
rtl/core/msm_if.sv
rtl/core/msm_div.sv
rtl/core/msm_ctrl.sv
rtl/core/msm_dp.sv
rtl/core/motion_adaptive_position_smoother_unit.sv
dv/tb_motion_adaptive_position_smoother_unit.sv
